/* design/mmn_pkg.sv */
`timescale 1ns / 1ps

package mmn_pkg;

    localparam int unsigned SAMPLE_BITS_DEF = 16;
    localparam int unsigned OUT_MAX_DEF     = 4095;
    localparam int unsigned SCALED_W        = 12;
    localparam int unsigned M_TDATA_W       = ((SCALED_W + 7) / 8) * 8;
    localparam int unsigned S_TUSER_W       = 2;

    // tuser bit positions on the input side
    localparam int unsigned TUSER_OP    = 0;
    localparam int unsigned TUSER_FIRST = 1;

    // op codes
    localparam logic OP_MEASURE   = 1'b0;
    localparam logic OP_NORMALIZE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    typedef struct packed {
        logic measure;
        logic capture;
        logic prep;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic special;
    } status_t;

endpackage

/* design/min_max_normalizer.sv */
`timescale 1ns / 1ps
// sequence: a normalize item is captured, then ST_PREP forms the operands, ST_DIV runs the
// divider and ST_FIN loads the output register once it is free; a clamped sample or an
// empty range skips the divider steps; no input is taken again until that load
// the divider is a 12-step restoring one by default (one quotient bit per cycle, quotient width follows OUT_MAX)
// a measure item is taken in ST_IDLE and only updates the range registers
// reset: synchronous active-low aresetn empties the output and restores the empty range

module min_max_normalizer #(
    parameter int unsigned SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned OUT_MAX     = mmn_pkg::OUT_MAX_DEF,
    localparam int unsigned S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [S_TDATA_W-1:0]            s_axis_tdata,  // sample, zero pad
    input  logic [mmn_pkg::S_TUSER_W-1:0]   s_axis_tuser,  // op, first
    input  logic                            s_axis_tlast,  // last
    // result channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mmn_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // scaled, zero pad
    output logic                            m_axis_tlast   // end_of_image
);
    import mmn_pkg::*;

    cmd_t                         cmd;
    status_t                      status;
    logic [SCALED_W-1:0]          scaled;

    // sequencer: accepts items, steps the divider, owns the output valid
    mmn_ctrl #(
        .OUT_MAX (OUT_MAX)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_axis_tvalid),
        .s_op_i    (s_axis_tuser[TUSER_OP]),
        .s_ready_o (s_axis_tready),
        .m_ready_i (m_axis_tready),
        .m_valid_o (m_axis_tvalid),
        .cmd_o     (cmd),
        .status_i  (status)
    );

    // range registers, multiplier, divider and output register
    mmn_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OUT_MAX     (OUT_MAX)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_i    (cmd),
        .status_o (status),
        .first_i  (s_axis_tuser[TUSER_FIRST]),
        .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
        .last_i   (s_axis_tlast),
        .scaled_o (scaled),
        .eoi_o    (m_axis_tlast)
    );

    // scaled sits in the low bits, upper pad is zero
    assign m_axis_tdata = M_TDATA_W'(scaled);

endmodule

/* design/mmn_datapath.sv */
`timescale 1ns / 1ps

module mmn_datapath #(
    parameter int unsigned SAMPLE_BITS = mmn_pkg::SAMPLE_BITS_DEF,
    parameter int unsigned OUT_MAX     = mmn_pkg::OUT_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mmn_pkg::cmd_t                     cmd_i,
    output mmn_pkg::status_t                  status_o,
    input  logic                              first_i,
    input  logic signed [SAMPLE_BITS-1:0]     sample_i,
    input  logic                              last_i,
    output logic [mmn_pkg::SCALED_W-1:0]      scaled_o,
    output logic                              eoi_o
);
    import mmn_pkg::*;

    localparam int unsigned SB = SAMPLE_BITS;
    localparam int unsigned QW = $clog2(OUT_MAX + 1);
    localparam int unsigned PW = SB + QW;

    localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};
    localparam logic [QW-1:0]        OMAX     = QW'(OUT_MAX);

    logic signed [SB-1:0] low_reg, low_next;
    logic signed [SB-1:0] high_reg, high_next;
    logic signed [SB-1:0] smp_reg;
    logic                 last_reg;
    logic [SB-1:0]        den_reg;
    logic [SB-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        lowbits_reg, lowbits_next;
    logic [QW-1:0]        quot_reg, quot_next;
    logic                 zero_reg, full_reg;
    logic [SCALED_W-1:0]  scaled_reg;
    logic                 eoi_reg;

    logic signed [SB:0]   num_w, den_w;
    logic                 zero_w, full_w;
    logic [PW-1:0]        prod_w;
    logic [SB:0]          shifted_w;
    logic [SB+1:0]        trial_w;

    // range tracking in the measure pass
    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (first_i) begin
            low_next  = sample_i;
            high_next = sample_i;
        end else begin
            if (sample_i < low_reg)  low_next  = sample_i;
            if (sample_i > high_reg) high_next = sample_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= MOST_POS;
            high_reg <= MOST_NEG;
        end else if (cmd_i.measure) begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // operands and out-of-range cases
    assign num_w  = {smp_reg[SB-1], smp_reg} - {low_reg[SB-1], low_reg};
    assign den_w  = {high_reg[SB-1], high_reg} - {low_reg[SB-1], low_reg};
    assign zero_w = (high_reg <= low_reg) || (smp_reg <= low_reg);
    assign full_w = (smp_reg >= high_reg);
    assign prod_w = num_w[SB-1:0] * OMAX;

    // one restoring division step
    assign shifted_w = {rem_reg, lowbits_reg[QW-1]};
    assign trial_w   = {1'b0, shifted_w} - {2'b00, den_reg};

    always_comb begin
        rem_next     = rem_reg;
        lowbits_next = lowbits_reg;
        quot_next    = quot_reg;
        if (cmd_i.prep) begin
            rem_next     = prod_w[PW-1:QW];
            lowbits_next = prod_w[QW-1:0];
            quot_next    = '0;
        end else if (cmd_i.div_step) begin
            lowbits_next = lowbits_reg << 1;
            if (!trial_w[SB+1]) begin
                rem_next  = trial_w[SB-1:0];
                quot_next = QW'({quot_reg, 1'b1});
            end else begin
                rem_next  = shifted_w[SB-1:0];
                quot_next = QW'({quot_reg, 1'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            smp_reg  <= sample_i;
            last_reg <= last_i;
        end
        if (cmd_i.prep) begin
            den_reg  <= den_w[SB-1:0];
            zero_reg <= zero_w;
            full_reg <= full_w;
        end
        rem_reg     <= rem_next;
        lowbits_reg <= lowbits_next;
        quot_reg    <= quot_next;
        if (cmd_i.load_out) begin
            if (zero_reg)      scaled_reg <= '0;
            else if (full_reg) scaled_reg <= SCALED_W'(OUT_MAX);
            else               scaled_reg <= SCALED_W'(quot_reg);
            eoi_reg <= last_reg;
        end
    end

    assign status_o.special = zero_reg || full_reg;
    assign scaled_o         = scaled_reg;
    assign eoi_o            = eoi_reg;

endmodule

/* design/mmn_ctrl.sv */
`timescale 1ns / 1ps

module mmn_ctrl #(
    parameter int unsigned OUT_MAX = mmn_pkg::OUT_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid_i,
    input  logic              s_op_i,
    output logic              s_ready_o,
    input  logic              m_ready_i,
    output logic              m_valid_o,
    output mmn_pkg::cmd_t     cmd_o,
    input  mmn_pkg::status_t  status_i
);
    import mmn_pkg::*;

    localparam int unsigned QW = $clog2(OUT_MAX + 1);
    localparam int unsigned CW = $clog2(QW + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          accept, out_free;

    assign s_ready_o = (state_reg == ST_IDLE);
    assign accept    = s_valid_i && s_ready_o;
    assign out_free  = !m_valid_reg || m_ready_i;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_o          = '0;
        cmd_o.measure  = accept && (s_op_i == OP_MEASURE);
        cmd_o.capture  = accept && (s_op_i == OP_NORMALIZE);
        case (state_reg)
            ST_IDLE: begin
                if (cmd_o.capture) state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd_o.prep = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status_i.special) begin
                    state_next = ST_FIN;
                end else begin
                    cmd_o.div_step = 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(QW - 1)) state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    cmd_o.load_out = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd_o.load_out)  m_valid_next = 1'b1;
        else if (m_ready_i)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid_o = m_valid_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.load_out |-> (!m_valid_reg || m_ready_i))
        else $error("result loaded over an untaken transfer");

    a_norm_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op_i == OP_NORMALIZE) |=> (state_reg == ST_PREP))
        else $error("normalize item did not start preparation");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= CW'(QW - 1)))
        else $error("division step count out of range");

    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result valid without finishing a division");

endmodule

/* bench/min_max_normalizer_tb.sv */
`timescale 1ns / 1ps

module min_max_normalizer_tb;
    import mmn_pkg::*;

    localparam int unsigned SMP_W      = SAMPLE_BITS_DEF;
    localparam int unsigned S_DATA_W   = ((SMP_W + 7) / 8) * 8;
    localparam longint      FULL_SCALE = longint'(OUT_MAX_DEF);
    localparam int          CYCLE_LIMIT = 400000;
    // drain time after the last expected result has been taken
    localparam int          DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [SCALED_W-1:0] scaled;
        logic                end_of_image;
    } norm_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;   // sample, zero pad
    logic [S_TUSER_W-1:0]  s_axis_tuser;   // op, first
    logic                  s_axis_tlast;   // last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;   // scaled, zero pad
    logic                  m_axis_tlast;   // end_of_image

    // range tracked by the predictor, mirrors the block's min and max
    logic signed [SMP_W-1:0] img_low;
    logic signed [SMP_W-1:0] img_high;
    logic signed [SMP_W-1:0] in_sample;
    norm_result_t            pending_results[$];
    norm_result_t            want;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int fail_count = 0;
    int cycle_count = 0;

    min_max_normalizer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // floor((v - low) * full scale / (high - low)), clamped at both ends
    function automatic logic [SCALED_W-1:0] predict_scaled(
        input logic signed [SMP_W-1:0] lo,
        input logic signed [SMP_W-1:0] hi,
        input logic signed [SMP_W-1:0] v
    );
        longint num;
        longint den;
        longint q;
        if (hi <= lo || v <= lo) begin
            q = 0;
        end else if (v >= hi) begin
            q = FULL_SCALE;
        end else begin
            num = longint'(v) - longint'(lo);
            den = longint'(hi) - longint'(lo);
            q   = (num * FULL_SCALE) / den;
        end
        return q[SCALED_W-1:0];
    endfunction

    // receiver backpressure, rate set by the running phase
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // predictor and checker: values read here are the ones before the edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            img_low  = 16'sh7fff;
            img_high = 16'sh8000;
            pending_results.delete();
        end else begin
            // result transfer, compared with the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result scaled=%0d end_of_image=%0b",
                           m_axis_tdata[SCALED_W-1:0], m_axis_tlast);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[SCALED_W-1:0] !== want.scaled) begin
                        $error("scaled: expected %0d, got %0d",
                               want.scaled, m_axis_tdata[SCALED_W-1:0]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.end_of_image) begin
                        $error("end_of_image: expected %0b, got %0b",
                               want.end_of_image, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            // input transfer: measure widens the range, normalize queues a result
            if (s_axis_tvalid && s_axis_tready) begin
                in_sample = s_axis_tdata[SMP_W-1:0];
                if (s_axis_tuser[TUSER_OP] == OP_MEASURE) begin
                    if (s_axis_tuser[TUSER_FIRST]) begin
                        img_low  = in_sample;
                        img_high = in_sample;
                    end else begin
                        if (in_sample < img_low)
                            img_low = in_sample;
                        if (in_sample > img_high)
                            img_high = in_sample;
                    end
                end else begin
                    pending_results.push_back(
                        '{predict_scaled(img_low, img_high, in_sample), s_axis_tlast});
                end
            end
        end
    end

    // one input transfer, with random idle cycles ahead of it
    task automatic send_voxel(input logic op, input logic first,
                              input logic [SMP_W-1:0] smp, input logic last);
        logic [S_TUSER_W-1:0] u;
        u              = '0;
        u[TUSER_OP]    = op;
        u[TUSER_FIRST] = first;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'(smp);
        s_axis_tuser  <= u;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        items_sent++;
    endtask

    // normalize straight after reset sees the empty range
    task automatic test_empty_range();
        send_voxel(OP_NORMALIZE, 1'b0, 16'h0000, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b1, 16'h8000, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'h7fff, 1'b1);
    endtask

    // a single-valued range gives zero everywhere
    task automatic test_flat_range();
        send_voxel(OP_MEASURE,   1'b1, 16'd5, 1'b1);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd5, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd6, 1'b1);
    endtask

    // the widest range the sample field allows
    task automatic test_full_scale();
        send_voxel(OP_MEASURE,   1'b1, 16'h8000, 1'b0);
        send_voxel(OP_MEASURE,   1'b0, 16'h7fff, 1'b1);
        send_voxel(OP_NORMALIZE, 1'b0, 16'h8000, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'h0000, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'hffff, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'h7fff, 1'b1);
    endtask

    // samples below and above the measured range clamp
    task automatic test_out_of_range();
        send_voxel(OP_MEASURE,   1'b1, 16'd100, 1'b0);
        send_voxel(OP_MEASURE,   1'b0, 16'd200, 1'b1);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd50,  1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd300, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd150, 1'b0);
        send_voxel(OP_NORMALIZE, 1'b1, 16'd199, 1'b1);
    endtask

    // measure without first keeps the old range and widens it
    task automatic test_range_extension();
        send_voxel(OP_MEASURE,   1'b0, 16'd300,  1'b0);
        send_voxel(OP_MEASURE,   1'b0, 16'hfff0, 1'b1);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd250,  1'b0);
        send_voxel(OP_NORMALIZE, 1'b0, 16'd0,    1'b1);
    endtask

    // mostly whole images (measure pass, then normalize pass), some noise
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        logic [SMP_W-1:0] vox[$];
        logic [SMP_W-1:0] base;
        logic [SMP_W-1:0] smp;
        int               stop_at;
        int               n;
        int               spread;
        int               kind;
        bit               skip_first;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = items_sent + n_items;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: any op, any flags
                repeat ($urandom_range(1, 4))
                    send_voxel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               SMP_W'($urandom_range(0, 16'hffff)),
                               1'($urandom_range(0, 1)));
            end else begin
                n    = $urandom_range(1, 12);
                base = SMP_W'($urandom_range(0, 16'hffff));
                case ($urandom_range(0, 3))
                    0: spread = 16'hffff;
                    1: spread = 15;
                    2: spread = 1000;
                    default: spread = 0;
                endcase
                vox.delete();
                repeat (n) begin
                    if (spread == 16'hffff)
                        vox.push_back(SMP_W'($urandom_range(0, 16'hffff)));
                    else
                        vox.push_back(base + SMP_W'($urandom_range(0, spread)));
                end
                // occasionally a broken image that never restarts the range
                skip_first = ($urandom_range(0, 7) == 0);
                foreach (vox[i])
                    send_voxel(OP_MEASURE, (i == 0) && !skip_first, vox[i],
                               (i == n - 1) ? 1'b1 : 1'(($urandom_range(0, 7) == 0)));
                // normalize pass, sometimes cut short or off-range samples
                if ($urandom_range(0, 5) == 0)
                    n = $urandom_range(1, n);
                for (int i = 0; i < n; i++) begin
                    smp = vox[$urandom_range(0, vox.size() - 1)];
                    if ($urandom_range(0, 5) == 0)
                        smp = SMP_W'($urandom_range(0, 16'hffff));
                    send_voxel(OP_NORMALIZE, 1'(($urandom_range(0, 7) == 0)), smp,
                               i == n - 1);
                end
            end
        end
    endtask

    initial begin
        aresetn        <= 1'b0;
        s_axis_tvalid  <= 1'b0;
        s_axis_tdata   <= '0;
        s_axis_tuser   <= '0;
        s_axis_tlast   <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_range();
        test_flat_range();
        test_full_scale();
        test_out_of_range();
        test_range_extension();

        test_random_traffic(0,  0,  375);
        test_random_traffic(69, 0,  375);
        test_random_traffic(0,  69, 375);
        test_random_traffic(8,  8,  375);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
